// File: hw/rtl/decimal_telegram_receive_check_macros.svh
// Assertion macros shared by the telegram receive checker.
`ifndef DECIMAL_TELEGRAM_RECEIVE_CHECK_MACROS_SVH
`define DECIMAL_TELEGRAM_RECEIVE_CHECK_MACROS_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define DTRC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// Antecedent in any cycle implies consequent in the next.
`define DTRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DTRC_ASSERT_ALWAYS(lbl, cond, msg)
`define DTRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/dtrc_pkg.sv
package dtrc_pkg;

    localparam int ADDR_W  = 10;
    localparam int PARAM_W = 10;
    localparam int LEN_W   = 7;
    localparam int CSUM_W  = 10;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [ADDR_W-1:0]  RST_EXP_ADDR  = 10'd1;
    localparam logic [PARAM_W-1:0] RST_EXP_PARAM = 10'd0;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam int ERR_TEXT_LEN = 6;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXP_ADDR  = 1'b0,
        CFG_EXP_PARAM = 1'b1
    } t_cfg_idx;

    // Field being received
    typedef enum logic [2:0] {
        POS_ADDR   = 3'd0,
        POS_ACTION = 3'd1,
        POS_PARAM  = 3'd2,
        POS_LEN    = 3'd3,
        POS_DATA   = 3'd4,
        POS_CSUM   = 3'd5,
        POS_TERM   = 3'd6
    } t_pos;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CHECKSUM  = 3'd1,
        ST_ADDRESS   = 3'd2,
        ST_PARAMETER = 3'd3,
        ST_NO_DEF    = 3'd4,
        ST_RANGE     = 3'd5,
        ST_LOGIC     = 3'd6,
        ST_MALFORMED = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic               kind;
        logic [7:0]         data_byte;
        logic [ADDR_W-1:0]  address;
        logic [PARAM_W-1:0] parameter_res;
        logic [LEN_W-1:0]   data_length;
        logic [2:0]         status;
    } t_result;

    // Error reply texts: 0 NO_DEF, 1 _RANGE, 2 _LOGIC
    function automatic logic [7:0] err_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0: begin
                case (idx)
                    3'd0: c = "N";
                    3'd1: c = "O";
                    3'd2: c = "_";
                    3'd3: c = "D";
                    3'd4: c = "E";
                    3'd5: c = "F";
                    default: c = 8'h00;
                endcase
            end
            2'd1: begin
                case (idx)
                    3'd0: c = "_";
                    3'd1: c = "R";
                    3'd2: c = "A";
                    3'd3: c = "N";
                    3'd4: c = "G";
                    3'd5: c = "E";
                    default: c = 8'h00;
                endcase
            end
            2'd2: begin
                case (idx)
                    3'd0: c = "_";
                    3'd1: c = "L";
                    3'd2: c = "O";
                    3'd3: c = "G";
                    3'd4: c = "I";
                    3'd5: c = "C";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/dtrc_stream_if.sv
interface dtrc_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/dtrc_parse.sv
module dtrc_parse (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [7:0]                      i_byte,
    input  logic [dtrc_pkg::ADDR_W-1:0]     i_exp_addr,
    input  logic [dtrc_pkg::PARAM_W-1:0]    i_exp_param,
    output logic                            o_res_valid,
    output dtrc_pkg::t_result               o_res
);
    import dtrc_pkg::*;

    t_pos                r_pos,   n_pos;
    logic [LEN_W-1:0]    r_cnt,   n_cnt;
    logic [ADDR_W-1:0]   r_addr,  n_addr;
    logic [PARAM_W-1:0]  r_param, n_param;
    logic [LEN_W-1:0]    r_len,   n_len;
    logic [7:0]          r_sum,   n_sum;
    logic [CSUM_W-1:0]   r_csum,  n_csum;
    logic [2:0]          r_match, n_match;
    logic                r_bad,   n_bad;

    logic                is_digit;
    logic [3:0]          digit;
    logic [LEN_W-1:0]    cnt_inc;
    logic [LEN_W-1:0]    len_next;
    logic                bad_now;
    t_status             status;

    // digit decode; non-digits count as zero
    assign is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign digit    = is_digit ? 4'(i_byte - CHAR_ZERO) : 4'd0;
    assign cnt_inc  = r_cnt + 7'd1;
    assign len_next = 7'(r_len * 7'd10 + 7'(digit));
    assign bad_now  = r_bad || (i_byte != CHAR_CR);

    // summary status, highest priority first
    always_comb begin
        if (bad_now)
            status = ST_MALFORMED;
        else if (r_csum != {2'b00, r_sum})
            status = ST_CHECKSUM;
        else if (r_addr != i_exp_addr)
            status = ST_ADDRESS;
        else if (r_param != i_exp_param)
            status = ST_PARAMETER;
        else if (r_len == 7'd6 && r_match[0])
            status = ST_NO_DEF;
        else if (r_len == 7'd6 && r_match[1])
            status = ST_RANGE;
        else if (r_len == 7'd6 && r_match[2])
            status = ST_LOGIC;
        else
            status = ST_OK;
    end

    // per-byte state update and result
    always_comb begin
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_addr  = r_addr;
        n_param = r_param;
        n_len   = r_len;
        n_sum   = r_sum;
        n_csum  = r_csum;
        n_match = r_match;
        n_bad   = r_bad;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_en) begin
            unique case (r_pos)
                POS_ACTION: begin
                    n_sum = r_sum + i_byte;
                    n_bad = r_bad | ~is_digit;
                    n_cnt = cnt_inc;
                    if (cnt_inc == 7'd2) begin
                        n_pos = POS_PARAM;
                        n_cnt = '0;
                    end
                end
                POS_PARAM: begin
                    n_sum   = r_sum + i_byte;
                    n_bad   = r_bad | ~is_digit;
                    n_param = 10'(r_param * 10'd10 + 10'(digit));
                    n_cnt   = cnt_inc;
                    if (cnt_inc == 7'd3) begin
                        n_pos = POS_LEN;
                        n_cnt = '0;
                    end
                end
                POS_LEN: begin
                    n_sum = r_sum + i_byte;
                    n_bad = r_bad | ~is_digit;
                    n_len = len_next;
                    n_cnt = cnt_inc;
                    if (cnt_inc == 7'd2) begin
                        n_cnt = '0;
                        n_pos = (len_next == '0) ? POS_CSUM : POS_DATA;
                    end
                end
                POS_DATA: begin
                    n_sum = r_sum + i_byte;
                    for (int k = 0; k < 3; k++) begin
                        if (r_cnt >= 7'(ERR_TEXT_LEN) ||
                            err_char(2'(k), r_cnt[2:0]) != i_byte)
                            n_match[k] = 1'b0;
                    end
                    n_cnt = cnt_inc;
                    if (cnt_inc >= r_len) begin
                        n_pos = POS_CSUM;
                        n_cnt = '0;
                    end
                    o_res_valid     = 1'b1;
                    o_res.kind      = 1'b0;
                    o_res.data_byte = i_byte;
                end
                POS_CSUM: begin
                    n_bad  = r_bad | ~is_digit;
                    n_csum = 10'(r_csum * 10'd10 + 10'(digit));
                    n_cnt  = cnt_inc;
                    if (cnt_inc == 7'd3) begin
                        n_pos = POS_TERM;
                        n_cnt = '0;
                    end
                end
                POS_TERM: begin
                    o_res_valid         = 1'b1;
                    o_res.kind          = 1'b1;
                    o_res.address       = r_addr;
                    o_res.parameter_res = r_param;
                    o_res.data_length   = r_len;
                    o_res.status        = status;
                    // back to a clean telegram
                    n_pos   = POS_ADDR;
                    n_cnt   = '0;
                    n_addr  = '0;
                    n_param = '0;
                    n_len   = '0;
                    n_sum   = '0;
                    n_csum  = '0;
                    n_match = 3'b111;
                    n_bad   = 1'b0;
                end
                // address field, also any unused position code
                default: begin
                    n_sum  = r_sum + i_byte;
                    n_bad  = r_bad | ~is_digit;
                    n_addr = 10'(r_addr * 10'd10 + 10'(digit));
                    n_cnt  = cnt_inc;
                    if (cnt_inc == 7'd3) begin
                        n_pos = POS_ACTION;
                        n_cnt = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_ADDR;
            r_cnt   <= '0;
            r_addr  <= '0;
            r_param <= '0;
            r_len   <= '0;
            r_sum   <= '0;
            r_csum  <= '0;
            r_match <= 3'b111;
            r_bad   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_addr  <= n_addr;
            r_param <= n_param;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_csum  <= n_csum;
            r_match <= n_match;
            r_bad   <= n_bad;
        end
    end

endmodule

// File: hw/rtl/decimal_telegram_receive_check.sv
// A byte is captured in the input register; its result (if any) is then
// captured in the result register and shown on o_res.
// Throughput: one byte per cycle, stalled while a result waits on o_res.ready low.
// Reset (synchronous, i_rst_n low): pipeline empty, parser at the address field,
// expected address 1, expected parameter 0.
module decimal_telegram_receive_check (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dtrc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dtrc_pkg::CFG_W-1:0]         i_cfg_data,
    dtrc_stream_if.sink                        i_rx,
    dtrc_stream_if.source                      o_res
);
    import dtrc_pkg::*;

`include "decimal_telegram_receive_check_macros.svh"

    logic [ADDR_W-1:0]  r_exp_addr;
    logic [PARAM_W-1:0] r_exp_param;
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    t_result            r_out;

    logic               out_free;
    logic               proc_en;
    logic               res_valid;
    t_result            res;
    t_rx_item           rx_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr  <= RST_EXP_ADDR;
            r_exp_param <= RST_EXP_PARAM;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_EXP_ADDR:  r_exp_addr  <= i_cfg_data[ADDR_W-1:0];
                CFG_EXP_PARAM: r_exp_param <= i_cfg_data[PARAM_W-1:0];
                default: ;
            endcase
        end
    end

    // stage one drains whenever the output register can take its result
    assign out_free   = !r_out_valid || o_res.ready;
    assign proc_en    = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || out_free;
    assign rx_item    = i_rx.data;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= rx_item.rx_byte;
        end
    end

    dtrc_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (proc_en),
        .i_byte      (r_in_byte),
        .i_exp_addr  (r_exp_addr),
        .i_exp_param (r_exp_param),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc_en && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && proc_en && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // checks
    `DTRC_ASSERT_ALWAYS(a_empty_out_takes_input, !r_out_valid |-> i_rx.ready, "input stalled with empty output")
    `DTRC_ASSERT_NEXT(a_transfer_loads_stage, i_rx.valid && i_rx.ready, r_in_valid, "transfer lost at input register")
    `DTRC_ASSERT_ALWAYS(a_result_fields_clean, r_out_valid |-> (r_out.kind ? (r_out.data_byte == 8'd0) : (r_out.status == 3'd0 && r_out.address == '0)), "result fields of the other kind not zero")

endmodule
